>>> src/sdc_pkg.sv
package sdc_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] local_offset;
    logic [63:0] remote_addr;
    logic [63:0] block_bytes;
    logic [63:0] run_bytes;
    logic [63:0] stride_a;
    logic [63:0] stride_b;
    logic [63:0] stride_c;
    logic [63:0] count_a;
    logic [63:0] count_b;
    logic [63:0] count_c;
    logic [7:0]  elem_format;
  } sdc_in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] element_count;
    logic [31:0] encoded_count_a;
    logic [31:0] encoded_count_b;
    logic [31:0] encoded_count_c;
    logic [63:0] source_end;
    logic [63:0] dest_end;
  } sdc_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        bad;
    logic        kind;
    logic [31:0] elems;
    logic [31:0] cm1_a;
    logic [31:0] cm1_b;
    logic [31:0] cm1_c;
    logic [31:0] stride_a;
    logic [31:0] stride_b;
    logic [31:0] stride_c;
    logic [64:0] rem_base;
    logic [64:0] loc_end;
  } sdc_cls_t;

  // log2 of element size; returns 2'b00 for unknown and packed too
  function automatic logic [1:0] fmt_shift(input logic [7:0] fmt);
    logic [1:0] s;
    s = 2'd0;
    case (fmt)
      8'd1, 8'd2, 8'd3, 8'd9:   s = 2'd1;
      8'd4, 8'd5, 8'd6, 8'd10:  s = 2'd2;
      8'd11, 8'd12:             s = 2'd3;
      default:                  s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

>>> src/sdc_front.sv
module sdc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sdc_pkg::sdc_in_t  in_data,
  output logic              f_valid,
  input  logic              f_ready,
  output sdc_pkg::sdc_cls_t f_data
);

  logic              v_r;
  sdc_pkg::sdc_cls_t d_r;
  sdc_pkg::sdc_cls_t d_nxt;
  logic [1:0]        sh;
  logic              packed_fmt;
  logic              bad;
  logic [63:0]       elems64;

  assign in_full = v_r && !f_ready;
  assign f_valid = v_r;
  assign f_data  = d_r;

  always_comb begin
    sh         = sdc_pkg::fmt_shift(in_data.elem_format);
    packed_fmt = (in_data.elem_format == 8'd7);
    bad = (in_data.count_a == 64'd0) || (in_data.count_b == 64'd0) ||
          (in_data.count_c == 64'd0) ||
          (in_data.count_a[63:32] != 32'd0) || (in_data.count_b[63:32] != 32'd0) ||
          (in_data.count_c[63:32] != 32'd0) ||
          (in_data.stride_a[63:32] != 32'd0) || (in_data.stride_b[63:32] != 32'd0) ||
          (in_data.stride_c[63:32] != 32'd0) ||
          (in_data.block_bytes == 64'd0) || (in_data.run_bytes == 64'd0) ||
          (in_data.run_bytes > in_data.block_bytes) ||
          (in_data.elem_format > 8'd12);
    if (packed_fmt) begin
      elems64 = {in_data.run_bytes[60:0], 3'b000};
      bad = bad || (in_data.run_bytes[63:29] != 35'd0);
    end else begin
      elems64 = in_data.run_bytes >> sh;
      case (sh)
        2'd1:    bad = bad || in_data.run_bytes[0];
        2'd2:    bad = bad || (in_data.run_bytes[1:0] != 2'd0);
        2'd3:    bad = bad || (in_data.run_bytes[2:0] != 3'd0);
        default: bad = bad;
      endcase
      bad = bad || (elems64[63:32] != 32'd0);
    end
    d_nxt.bad         = bad;
    d_nxt.kind        = in_data.kind;
    d_nxt.elems       = elems64[31:0];
    d_nxt.cm1_a       = in_data.count_a[31:0] - 32'd1;
    d_nxt.cm1_b       = in_data.count_b[31:0] - 32'd1;
    d_nxt.cm1_c       = in_data.count_c[31:0] - 32'd1;
    d_nxt.stride_a    = in_data.stride_a[31:0];
    d_nxt.stride_b    = in_data.stride_b[31:0];
    d_nxt.stride_c    = in_data.stride_c[31:0];
    // remote start plus one inner run; the back adds the stride products
    d_nxt.rem_base    = {1'b0, in_data.remote_addr} + {1'b0, in_data.run_bytes};
    d_nxt.loc_end     = {33'd0, in_data.local_offset} + {1'b0, in_data.block_bytes};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!in_full) begin
      v_r <= in_push;
    end
    if (in_push && !in_full) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> src/sdc_back.sv
module sdc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              f_valid,
  output logic              f_ready,
  input  sdc_pkg::sdc_cls_t f_data,
  output logic              out_empty,
  input  logic              out_pop,
  output sdc_pkg::sdc_out_t out_data
);

  // stage 1: three 32x32 products
  logic              v1_r;
  sdc_pkg::sdc_cls_t c1_r;
  logic [63:0]       pa_r, pb_r, pc_r;
  // stage 2: end sums
  logic              v2_r;
  sdc_pkg::sdc_out_t o2_r;
  sdc_pkg::sdc_out_t o_nxt;

  logic adv2, adv1;
  logic [66:0] rem_end;
  logic        bad;

  assign out_empty = !v2_r;
  assign out_data  = o2_r;
  assign adv2      = !v2_r || out_pop;
  assign adv1      = !v1_r || adv2;
  assign f_ready   = adv1;

  always_comb begin
    // all terms are non-negative, so a span overflow also overflows the end
    rem_end = {2'd0, c1_r.rem_base} + {3'd0, pa_r} + {3'd0, pb_r} + {3'd0, pc_r};
    bad     = c1_r.bad || (rem_end[66:64] != 3'd0) || c1_r.loc_end[64];
    o_nxt = '0;
    o_nxt.status = 1'b1;
    if (!bad) begin
      o_nxt.status          = 1'b0;
      o_nxt.element_count   = c1_r.elems;
      o_nxt.encoded_count_a = c1_r.cm1_a;
      o_nxt.encoded_count_b = c1_r.cm1_b;
      o_nxt.encoded_count_c = c1_r.cm1_c;
      if (!c1_r.kind) begin
        o_nxt.source_end = rem_end[63:0] - 64'd1;
        o_nxt.dest_end   = c1_r.loc_end[63:0] - 64'd1;
      end else begin
        o_nxt.source_end = c1_r.loc_end[63:0] - 64'd1;
        o_nxt.dest_end   = rem_end[63:0] - 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= f_valid;
      if (adv2) v2_r <= v1_r;
    end
    if (adv1 && f_valid) begin
      c1_r <= f_data;
      pa_r <= {32'd0, f_data.cm1_a} * {32'd0, f_data.stride_a};
      pb_r <= {32'd0, f_data.cm1_b} * {32'd0, f_data.stride_b};
      pc_r <= {32'd0, f_data.cm1_c} * {32'd0, f_data.stride_c};
    end
    if (adv2 && v1_r) begin
      o2_r <= o_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_pop |=> v2_r && $stable(o2_r))
    else $error("result changed while stalled");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && o2_r.status |-> o2_r.element_count == 32'd0 && o2_r.source_end == 64'd0)
    else $error("invalid result carries data");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && adv2 |=> v2_r)
    else $error("stage 1 item lost");

endmodule

>>> src/strided_dma_descriptor_check_top.sv
// Strided DMA descriptor checker. Queue-style ports: push/full in, empty/pop
// out; one request accepted per cycle while full is low, one result per
// request, in order. A request passes the classify register, the stride
// multiply register and the end-address register; its result can be popped
// at the next edge after it shows. Stalls on pop back up through the stages,
// and full rises only when every stage holds a request and pop is low.
module strided_dma_descriptor_check_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sdc_pkg::sdc_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output sdc_pkg::sdc_out_t out_data
);

  logic              f_valid;
  logic              f_ready;
  sdc_pkg::sdc_cls_t f_data;

  sdc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_data  (f_data)
  );

  sdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_data    (f_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned LATENCY = 3;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  sdc_pkg::sdc_in_t in_data;
  logic out_empty;
  logic out_pop;
  sdc_pkg::sdc_out_t out_data;

  sdc_pkg::sdc_in_t pending_reqs[$];
  sdc_pkg::sdc_out_t expected_checks[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit stim_done;
  bit hold_off;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned pop_phase;

  strided_dma_descriptor_check_top u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic bit elem_shift(input logic [7:0] fmt, output int unsigned sh,
                                    output bit packed_fmt);
    packed_fmt = 1'b0;
    sh = 0;
    if (fmt == 8'd7) begin
      packed_fmt = 1'b1;
      return 1'b1;
    end
    if (fmt == 8'd0 || fmt == 8'd8) return 1'b1;
    if (fmt == 8'd1 || fmt == 8'd2 || fmt == 8'd3 || fmt == 8'd9) begin
      sh = 1;
      return 1'b1;
    end
    if (fmt == 8'd4 || fmt == 8'd5 || fmt == 8'd6 || fmt == 8'd10) begin
      sh = 2;
      return 1'b1;
    end
    if (fmt == 8'd11 || fmt == 8'd12) begin
      sh = 3;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // wide arithmetic lets each 64-bit overflow show as nonzero upper bits
  function automatic sdc_pkg::sdc_out_t check_descriptor(input sdc_pkg::sdc_in_t r);
    sdc_pkg::sdc_out_t res;
    logic [127:0] span;
    logic [127:0] elems;
    logic [127:0] rem_end;
    logic [127:0] loc_end;
    logic [63:0] strides[3];
    logic [63:0] counts[3];
    int unsigned sh;
    bit packed_fmt;
    bit ok;
    res = '0;
    res.status = 1'b1;
    strides = '{r.stride_a, r.stride_b, r.stride_c};
    counts = '{r.count_a, r.count_b, r.count_c};
    ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (counts[i] == 0 || counts[i] > 64'hFFFF_FFFF || strides[i] > 64'hFFFF_FFFF) ok = 1'b0;
    end
    if (r.block_bytes == 0 || r.run_bytes == 0 || r.run_bytes > r.block_bytes) ok = 1'b0;
    if (ok && !elem_shift(r.elem_format, sh, packed_fmt)) ok = 1'b0;
    if (!ok) return res;
    if (packed_fmt) begin
      elems = {64'd0, r.run_bytes} << 3;
    end else begin
      if ((r.run_bytes & ((64'd1 << sh) - 1)) != 0) return res;
      elems = {64'd0, r.run_bytes} >> sh;
    end
    if (elems > 128'hFFFF_FFFF) return res;
    span = {64'd0, r.run_bytes};
    for (int i = 0; i < 3; i++) span += (counts[i] - 1) * {64'd0, strides[i]};
    if (span[127:64] != 0) return res;
    rem_end = {64'd0, r.remote_addr} + span;
    loc_end = {96'd0, r.local_offset} + {64'd0, r.block_bytes};
    if (rem_end[127:64] != 0 || loc_end[127:64] != 0) return res;
    res.status = 1'b0;
    res.element_count = elems[31:0];
    res.encoded_count_a = 32'(r.count_a - 1);
    res.encoded_count_b = 32'(r.count_b - 1);
    res.encoded_count_c = 32'(r.count_c - 1);
    if (r.kind == 1'b0) begin
      res.source_end = rem_end[63:0] - 1;
      res.dest_end = loc_end[63:0] - 1;
    end else begin
      res.source_end = loc_end[63:0] - 1;
      res.dest_end = rem_end[63:0] - 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 64'd1;
      1: return 64'hFFFF_FFFF;
      2: return 64'd0;
      3: return rand64();
      default: return 64'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [63:0] pick_stride();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF;
      2: return {32'd0, $urandom()};
      3: return rand64();
      default: return 64'($urandom_range(0, 4096));
    endcase
  endfunction

  // mostly legal descriptors with random content, the rest noise
  function automatic sdc_pkg::sdc_in_t random_request();
    sdc_pkg::sdc_in_t r;
    int unsigned sh;
    bit packed_fmt;
    if ($urandom_range(0, 9) == 0) begin
      r = {1'b0, $urandom(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
           rand64(), rand64(), rand64(), rand64(), 8'($urandom())};
      r.kind = 1'($urandom_range(0, 1));
      return r;
    end
    r.kind = 1'($urandom_range(0, 1));
    r.local_offset = $urandom();
    r.elem_format = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 12));
    void'(elem_shift(r.elem_format, sh, packed_fmt));
    r.run_bytes = 64'($urandom_range(1, 256)) << sh;
    if ($urandom_range(0, 15) == 0) r.run_bytes = rand64();
    if ($urandom_range(0, 15) == 0) r.run_bytes = r.run_bytes + 64'd1;
    r.block_bytes = r.run_bytes + 64'($urandom_range(0, 4096));
    if ($urandom_range(0, 15) == 0) r.block_bytes = rand64();
    r.remote_addr = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom());
    r.stride_a = pick_stride();
    r.stride_b = pick_stride();
    r.stride_c = pick_stride();
    r.count_a = pick_count();
    r.count_b = pick_count();
    r.count_c = pick_count();
    return r;
  endfunction

  function automatic sdc_pkg::sdc_in_t base_request();
    sdc_pkg::sdc_in_t r;
    r = '0;
    r.local_offset = 32'h100;
    r.remote_addr = 64'h1000;
    r.block_bytes = 64'd64;
    r.run_bytes = 64'd16;
    r.stride_a = 64'd32;
    r.stride_b = 64'd256;
    r.stride_c = 64'd4096;
    r.count_a = 64'd2;
    r.count_b = 64'd2;
    r.count_c = 64'd1;
    r.elem_format = 8'd4;
    return r;
  endfunction

  initial begin
    sdc_pkg::sdc_in_t r;
    error_count = 0;
    stim_done = 1'b0;
    r = base_request();
    pending_reqs.push_back(r);
    r.kind = 1'b1;
    pending_reqs.push_back(r);
    for (int f = 0; f <= 13; f++) begin
      r = base_request();
      r.kind = f[0];
      r.elem_format = 8'(f);
      pending_reqs.push_back(r);
    end
    r = base_request(); r.elem_format = 8'hFF; pending_reqs.push_back(r);
    r = base_request(); r.count_b = 64'd0; pending_reqs.push_back(r);
    r = base_request(); r.stride_c = 64'h1_0000_0000; pending_reqs.push_back(r);
    r = base_request(); r.run_bytes = 64'd128; pending_reqs.push_back(r);
    r = base_request(); r.run_bytes = 64'd6; pending_reqs.push_back(r);
    // packed format: element count just above 32 bits, and times eight wrapping
    r = base_request(); r.elem_format = 8'd7; r.run_bytes = 64'h2000_0000;
    r.block_bytes = '1; pending_reqs.push_back(r);
    r.run_bytes = 64'h2000_0000_0000_0000; pending_reqs.push_back(r);
    // counts and strides at the top, remote address at zero and at the top of memory
    r = base_request(); r.count_a = 64'hFFFF_FFFF; r.count_b = 64'hFFFF_FFFF;
    r.count_c = 64'hFFFF_FFFF; r.stride_a = 64'hFFFF_FFFF; r.stride_b = 64'hFFFF_FFFF;
    r.stride_c = 64'hFFFF_FFFF; r.remote_addr = 64'h0; pending_reqs.push_back(r);
    r.remote_addr = '1; pending_reqs.push_back(r);
    r = base_request(); r.local_offset = '1; r.block_bytes = '1; r.run_bytes = '1;
    r.elem_format = 8'd0; pending_reqs.push_back(r);
    for (int n = 0; n < 450; n++) pending_reqs.push_back(random_request());
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_push && !in_full) expected_checks.push_back(check_descriptor(in_data));
      if (!in_push || !in_full) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_push <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_push <= 1'b1;
          in_data <= pending_reqs.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off early in the run so the pipe fills
  initial begin
    hold_off = 1'b0;
    wait (rst_n);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_phase <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_checks.size() == 0) begin
          $display("Unexpected result transaction");
          error_count++;
        end else begin
          sdc_pkg::sdc_out_t want;
          want = expected_checks.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.element_count !== want.element_count)
            report_mismatch("element_count", 64'(out_data.element_count),
                            64'(want.element_count));
          if (out_data.encoded_count_a !== want.encoded_count_a)
            report_mismatch("encoded_count_a", 64'(out_data.encoded_count_a),
                            64'(want.encoded_count_a));
          if (out_data.encoded_count_b !== want.encoded_count_b)
            report_mismatch("encoded_count_b", 64'(out_data.encoded_count_b),
                            64'(want.encoded_count_b));
          if (out_data.encoded_count_c !== want.encoded_count_c)
            report_mismatch("encoded_count_c", 64'(out_data.encoded_count_c),
                            64'(want.encoded_count_c));
          if (out_data.source_end !== want.source_end)
            report_mismatch("source_end", out_data.source_end, want.source_end);
          if (out_data.dest_end !== want.dest_end)
            report_mismatch("dest_end", out_data.dest_end, want.dest_end);
        end
      end
      pop_phase <= pop_phase + 1;
      // stall pattern: pseudo-random stalls alternating with free-running stretches
      if (hold_off) out_pop <= 1'b0;
      else if (pop_phase[8]) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(0, 3) != 0) && (pop_phase[2:0] != 3'd5);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    fork
      begin
        wait (stim_done && pending_reqs.size() == 0 && !in_push
              && expected_checks.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      wait (idle_cycles >= STALL_LIMIT);
    join_any
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout waiting for transactions");
      $display("Testbench completed WITH ERRORS");
    end else if (error_count == 0 && expected_checks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> strided_dma_descriptor_check_top.f
src/sdc_pkg.sv
src/sdc_front.sv
src/sdc_back.sv
src/strided_dma_descriptor_check_top.sv
tb/sv/tb_top.sv
